// ----- sv/rcm_pkg.sv -----
// rcm_pkg: shared constants, register codes and control types for the RMS current meter.
// No dependencies.

package rcm_pkg;

    localparam int ADC_BITS_DEF     = 12;
    localparam int OFFSET_SHIFT_DEF = 10;
    localparam int OFFSET_FRAC_DEF  = 20;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = 16'd1048;
    localparam logic [CFG_W-1:0] ICAL_GAIN_RST    = 16'd23270;

    localparam int RMS_W       = 20;
    localparam int MA_W        = 16;
    localparam int M_DATA_W    = 40;
    localparam int VREF_W      = 12;
    localparam int SCALE_SHIFT = 28;

    localparam logic [VREF_W-1:0] VREF_MV = 12'd3300;
    localparam logic [RMS_W-1:0]  RMS_MAX = 20'hFFFFF;
    localparam logic [MA_W-1:0]   MA_MAX  = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_ICAL_GAIN    = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic clear;
    } t_acc_ctl;

endpackage

// ----- sv/rcm_accum.sv -----
// rcm_accum: DC offset tracker, offset-removed square and square accumulator.
// Depends on rcm_pkg (t_acc_ctl).

module rcm_accum
    import rcm_pkg::*;
#(
    parameter int ADC_BITS     = ADC_BITS_DEF,
    parameter int OFFSET_SHIFT = OFFSET_SHIFT_DEF,
    parameter int OFFSET_FRAC  = OFFSET_FRAC_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_acc_ctl                                i_ctl,
    input  logic [ADC_BITS-1:0]                     i_sample,
    output logic [2*(ADC_BITS+8)+COUNT_BITS-1:0]    o_sum
);

    localparam int OFF_W = ADC_BITS + OFFSET_FRAC;
    localparam int MAG_W = ADC_BITS + 8;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + COUNT_BITS;
    localparam logic [OFF_W-1:0] OFF_RST = {1'b1, {(OFF_W-1){1'b0}}};

    logic [OFF_W-1:0]        r_off;
    logic [OFF_W-1:0]        n_off;
    logic [OFF_W-1:0]        r_s;
    logic [OFF_W-1:0]        s_in;
    logic signed [OFF_W:0]   diff;
    logic signed [OFF_W:0]   step;
    logic [OFF_W-1:0]        mag_full;
    logic [MAG_W-1:0]        mag;
    logic [SQ_W-1:0]         r_sq;
    logic [SUM_W-1:0]        r_sum;

    // floor step toward the sample: arithmetic shift of the signed difference
    always_comb begin
        s_in  = {i_sample, {OFFSET_FRAC{1'b0}}};
        diff  = $signed({1'b0, s_in}) - $signed({1'b0, r_off});
        step  = diff >>> OFFSET_SHIFT;
        n_off = r_off + step[OFF_W-1:0];
    end

    always_comb begin
        mag_full = (r_s >= r_off) ? (r_s - r_off) : (r_off - r_s);
        mag      = mag_full[OFF_W-1 -: MAG_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= OFF_RST;
            r_sum <= '0;
        end else begin
            if (i_ctl.load) begin
                r_off <= n_off;
            end
            if (i_ctl.clear) begin
                r_sum <= '0;
            end else if (i_ctl.accum) begin
                r_sum <= r_sum + SUM_W'(r_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s <= s_in;
        end
        if (i_ctl.square) begin
            r_sq <= mag * mag;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- sv/rcm_iter.sv -----
// rcm_iter: restoring divide then digit-by-digit square root on one shared subtractor.
// No package dependency.

module rcm_iter #(
    parameter int SUM_W = 56,
    parameter int DIV_W = 16,
    parameter int MAG_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_root
);

    localparam int SQ_W   = 2 * MAG_W;
    localparam int RS_W   = MAG_W + 1;
    localparam int ALU_W  = (DIV_W + 1 > MAG_W + 3) ? DIV_W + 1 : MAG_W + 3;
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_DIV  = 3'b010,
        P_SQRT = 3'b100
    } t_phase;

    t_phase              r_state;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_quo;
    logic [DIV_W-1:0]    r_rem_d;
    logic [DIV_W-1:0]    r_div;
    logic [SQ_W-1:0]     r_rad;
    logic [MAG_W-1:0]    r_root;
    logic [RS_W-1:0]     r_rem_s;

    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_W:0]      alu_diff;
    logic                alu_ge;

    // shared compare/subtract unit
    always_comb begin
        unique case (r_state)
            P_DIV: begin
                alu_a = ALU_W'({r_rem_d, r_quo[SUM_W-1]});
                alu_b = ALU_W'(r_div);
            end
            P_SQRT: begin
                alu_a = ALU_W'({r_rem_s, r_rad[SQ_W-1 -: 2]});
                alu_b = ALU_W'({r_root, 2'b01});
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_ge   = !alu_diff[ALU_W];
    end

    assign o_done = (r_state == P_SQRT) && (r_step == '0);
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_state <= P_DIV;
                        r_step  <= STEP_W'(SUM_W);
                    end
                end
                P_DIV: begin
                    if (r_step == '0) begin
                        r_state <= P_SQRT;
                        r_step  <= STEP_W'(MAG_W);
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                P_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= P_IDLE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                default: begin
                    r_state <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == P_IDLE && i_start) begin
            r_quo   <= i_dividend;
            r_rem_d <= '0;
            r_div   <= i_divisor;
        end else if (r_state == P_DIV) begin
            if (r_step == '0) begin
                // a mean past the root range clamps, so the root reads all ones
                r_rad   <= (|r_quo[SUM_W-1:SQ_W]) ? '1 : r_quo[SQ_W-1:0];
                r_root  <= '0;
                r_rem_s <= '0;
            end else begin
                r_rem_d <= alu_ge ? alu_diff[DIV_W-1:0] : alu_a[DIV_W-1:0];
                r_quo   <= {r_quo[SUM_W-2:0], alu_ge};
            end
        end else if (r_state == P_SQRT && r_step != '0) begin
            r_rem_s <= alu_ge ? alu_diff[RS_W-1:0] : alu_a[RS_W-1:0];
            r_root  <= {r_root[MAG_W-2:0], alu_ge};
            r_rad   <= {r_rad[SQ_W-3:0], 2'b00};
        end
    end

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == P_IDLE))
        else $error("rcm_iter: start while busy");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == P_DIV) |-> (r_rem_d < r_div))
        else $error("rcm_iter: divide remainder not below divisor");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == P_SQRT) |-> ({1'b0, r_rem_s} <= {1'b0, r_root, 1'b0}))
        else $error("rcm_iter: root remainder out of range");
`endif

endmodule

// ----- sv/rms_current_meter.sv -----
// rms_current_meter: top level, sequencer, config registers, scaling and output register.
// Depends on rcm_pkg, rcm_accum, rcm_iter.
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+-------------------------------------
//  cfg      | in  | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data (16 bits)
//  s_axis   | in  | s_axis_tvalid / s_axis_tready   | sample
//  m_axis   | out | m_axis_tvalid / m_axis_tready   | rms_counts, current_ma
//
// A sample that does not close a block passes S_SQR and S_ACC; s_axis_tready is high in S_IDLE.
// The closing sample also passes S_START, S_ROOT, S_MUL1, S_MUL2 and S_OUT; S_ROOT waits on the
// one-bit-per-cycle divider and two-bits-per-cycle root sharing one subtractor in rcm_iter.
// Synchronous active-low reset; no clearing pass. A pending result waits in the output register
// while the next sample is taken; a stalled m_axis holds the next block's result in S_OUT.

module rms_current_meter
    import rcm_pkg::*;
#(
    parameter int ADC_BITS     = ADC_BITS_DEF,
    parameter int OFFSET_SHIFT = OFFSET_SHIFT_DEF,
    parameter int OFFSET_FRAC  = OFFSET_FRAC_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_index,
    input  logic [CFG_W-1:0]                     i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]        s_axis_tdata,   // sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [M_DATA_W-1:0]                  m_axis_tdata    // rms_counts, current_ma
);

    localparam int MAG_W = ADC_BITS + 8;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + COUNT_BITS;
    localparam int EC_W  = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int RX_W  = (MAG_W > RMS_W) ? MAG_W : RMS_W;
    localparam int P1_W  = RMS_W + CFG_W;
    localparam int P2_W  = P1_W + VREF_W;
    localparam int MF_W  = P2_W - SCALE_SHIFT;
    localparam logic [EC_W-1:0] CNT_MAX = EC_W'((1 << COUNT_BITS) - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQR   = 8'b0000_0010,
        S_ACC   = 8'b0000_0100,
        S_START = 8'b0000_1000,
        S_ROOT  = 8'b0001_0000,
        S_MUL1  = 8'b0010_0000,
        S_MUL2  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [COUNT_BITS-1:0] r_seen;
    logic [COUNT_BITS-1:0] n_seen;
    logic [CFG_W-1:0]      r_sample_count;
    logic [CFG_W-1:0]      r_ical;
    logic [RMS_W-1:0]      r_rms;
    logic [P1_W-1:0]       r_prod1;
    logic [P2_W-1:0]       r_prod2;
    logic                  r_m_valid;
    logic [RMS_W-1:0]      r_o_rms;
    logic [MA_W-1:0]       r_o_ma;

    t_acc_ctl              acc_ctl;
    logic [SUM_W-1:0]      acc_sum;
    logic                  iter_start;
    logic                  iter_done;
    logic [MAG_W-1:0]      iter_root;
    logic [EC_W-1:0]       sc_x;
    logic [EC_W-1:0]       eff_x;
    logic [COUNT_BITS-1:0] eff_cnt;
    logic [COUNT_BITS-1:0] seen_inc;
    logic [RX_W-1:0]       root_x;
    logic [RMS_W-1:0]      rms_sat;
    logic [MF_W-1:0]       ma_full;
    logic [MA_W-1:0]       ma_sat;
    logic                  out_free;
    logic                  blk_end;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_DATA_W-RMS_W-MA_W){1'b0}}, r_o_ma, r_o_rms};
    assign out_free      = !r_m_valid || m_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
            r_ical         <= ICAL_GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                CFG_ICAL_GAIN:    r_ical         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero count acts as one, large counts clamp to the counter range
    always_comb begin
        sc_x     = EC_W'(r_sample_count);
        eff_x    = (sc_x == '0) ? EC_W'(1) : ((sc_x > CNT_MAX) ? CNT_MAX : sc_x);
        eff_cnt  = eff_x[COUNT_BITS-1:0];
        seen_inc = r_seen + 1'b1;
        blk_end  = (seen_inc >= eff_cnt);
    end

    always_comb begin
        acc_ctl.load   = s_axis_tvalid && s_axis_tready;
        acc_ctl.square = (r_state == S_SQR);
        acc_ctl.accum  = (r_state == S_ACC);
        acc_ctl.clear  = (r_state == S_START);
        iter_start     = (r_state == S_START);
    end

    always_comb begin
        root_x  = RX_W'(iter_root);
        rms_sat = (root_x > RX_W'(RMS_MAX)) ? RMS_MAX : root_x[RMS_W-1:0];
        ma_full = r_prod2[P2_W-1:SCALE_SHIFT];
        ma_sat  = (ma_full > MF_W'(MA_MAX)) ? MA_MAX : ma_full[MA_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        unique case (r_state)
            S_IDLE:  if (acc_ctl.load) n_state = S_SQR;
            S_SQR:   n_state = S_ACC;
            S_ACC: begin
                if (blk_end) begin
                    n_seen  = '0;
                    n_state = S_START;
                end else begin
                    n_seen  = seen_inc;
                    n_state = S_IDLE;
                end
            end
            S_START: n_state = S_ROOT;
            S_ROOT:  if (iter_done) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seen    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROOT && iter_done) begin
            r_rms <= rms_sat;
        end
        if (r_state == S_MUL1) begin
            r_prod1 <= r_rms * r_ical;
        end
        if (r_state == S_MUL2) begin
            r_prod2 <= r_prod1 * VREF_MV;
        end
        if (r_state == S_OUT && out_free) begin
            r_o_rms <= r_rms;
            r_o_ma  <= ma_sat;
        end
    end

    rcm_accum #(
        .ADC_BITS     (ADC_BITS),
        .OFFSET_SHIFT (OFFSET_SHIFT),
        .OFFSET_FRAC  (OFFSET_FRAC),
        .COUNT_BITS   (COUNT_BITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (acc_ctl),
        .i_sample (s_axis_tdata[ADC_BITS-1:0]),
        .o_sum    (acc_sum)
    );

    rcm_iter #(
        .SUM_W (SUM_W),
        .DIV_W (COUNT_BITS),
        .MAG_W (MAG_W)
    ) u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (iter_start),
        .i_dividend (acc_sum),
        .i_divisor  (eff_cnt),
        .o_done     (iter_done),
        .o_root     (iter_root)
    );

`ifndef ASSERT_OFF
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |=> (acc_sum == '0))
        else $error("rms_current_meter: accumulator not cleared at block end");

    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_done |-> (r_state == S_ROOT))
        else $error("rms_current_meter: root unit done outside wait state");

    a_seen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_seen == '0))
        else $error("rms_current_meter: sample counter not cleared during root");
`endif

endmodule

// ----- test/tb_rms_current_meter.sv -----
// tb_rms_current_meter: self-checking bench for the RMS current meter. A sample-by-sample model
// tracks the DC offset, sums squares and predicts each block's RMS and current reading.
// Depends on rcm_pkg and rms_current_meter.

module tb_rms_current_meter;
    import rcm_pkg::*;

    localparam int S_W        = ((ADC_BITS_DEF + 7) / 8) * 8;
    localparam int ITEMS      = 1550;
    localparam int SETTLE     = 120;
    localparam int LIMIT      = 2000000;
    localparam int SQUEEZE    = 500;
    localparam int MAX_REPORT = 100;

    typedef struct {
        logic [RMS_W-1:0] rms;
        logic [MA_W-1:0]  ma;
    } t_meter_reading;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_W-1:0]       s_axis_tdata;      // sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;      // rms_counts, current_ma

    rms_current_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // model state
    logic [63:0]        dc_level;
    logic [63:0]        energy_acc;
    logic [15:0]        blk_seen;
    logic [CFG_W-1:0]   reg_count;
    logic [CFG_W-1:0]   reg_gain;

    logic [ADC_BITS_DEF-1:0] sample_q[$];
    t_meter_reading          reading_q[$];

    logic in_taken;
    logic calm;
    logic squeeze_req;
    logic squeeze_done;
    int   hold_left;
    int   n_sent;
    int   n_taken;
    int   n_blocks;
    int   n_cfg;
    int   n_err;
    int   n_cycles;

    assign calm = (n_taken >= 600) && (n_taken < 900);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= v) r = b;
        end
        return r;
    endfunction

    task automatic meter_update(input logic [ADC_BITS_DEF-1:0] smp);
        logic [63:0]    s;
        logic [63:0]    mag;
        logic [63:0]    sq;
        logic [63:0]    mean;
        logic [63:0]    rms;
        logic [63:0]    ma;
        logic [15:0]    eff;
        t_meter_reading rd;
        s = 64'(smp) << OFFSET_FRAC_DEF;
        if (s >= dc_level)
            dc_level = dc_level + ((s - dc_level) >> OFFSET_SHIFT_DEF);
        else
            dc_level = dc_level - ((dc_level - s + ((64'd1 << OFFSET_SHIFT_DEF) - 1))
                                   >> OFFSET_SHIFT_DEF);
        mag = (s >= dc_level) ? (s - dc_level) : (dc_level - s);
        mag = mag >> (OFFSET_FRAC_DEF - 8);
        sq  = mag * mag;
        if (energy_acc > ~sq) energy_acc = '1;
        else energy_acc = energy_acc + sq;
        blk_seen = blk_seen + 16'd1;
        eff = (reg_count == '0) ? 16'd1 : reg_count;
        if (blk_seen >= eff) begin
            mean = energy_acc / 64'(eff);
            rms  = root_floor(mean);
            if (rms > 64'(RMS_MAX)) rms = 64'(RMS_MAX);
            ma = (rms * 64'(reg_gain) * 64'(VREF_MV)) >> SCALE_SHIFT;
            if (ma > 64'(MA_MAX)) ma = 64'(MA_MAX);
            rd.rms = rms[RMS_W-1:0];
            rd.ma  = ma[MA_W-1:0];
            reading_q.push_back(rd);
            energy_acc = '0;
            blk_seen   = '0;
        end
    endtask

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                s_axis_tdata  <= {{(S_W-ADC_BITS_DEF){1'b0}}, sample_q.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (squeeze_req && !squeeze_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= SQUEEZE;
            squeeze_done  <= 1'b1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    // monitor: config and sample transactions feed the model, results are checked
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg++;
                if (i_cfg_index == CFG_SAMPLE_COUNT) reg_count = i_cfg_data;
                else if (i_cfg_index == CFG_ICAL_GAIN) reg_gain = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_taken++;
                meter_update(s_axis_tdata[ADC_BITS_DEF-1:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_blocks++;
                if (reading_q.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORT)
                        $display("%0t: unexpected result: expected none, got rms %0d ma %0d",
                                 $time, m_axis_tdata[RMS_W-1:0],
                                 m_axis_tdata[RMS_W +: MA_W]);
                end else begin
                    t_meter_reading rd;
                    rd = reading_q.pop_front();
                    if (m_axis_tdata[RMS_W-1:0] !== rd.rms) begin
                        n_err++;
                        if (n_err <= MAX_REPORT)
                            $display("%0t: rms_counts mismatch: expected %0d, got %0d",
                                     $time, rd.rms, m_axis_tdata[RMS_W-1:0]);
                    end
                    if (m_axis_tdata[RMS_W +: MA_W] !== rd.ma) begin
                        n_err++;
                        if (n_err <= MAX_REPORT)
                            $display("%0t: current_ma mismatch: expected %0d, got %0d",
                                     $time, rd.ma, m_axis_tdata[RMS_W +: MA_W]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, reading_q.size());
            $display("rms_current_meter test failed");
            $finish;
        end
    end

    task automatic send(input logic [ADC_BITS_DEF-1:0] smp);
        sample_q.push_back(smp);
        n_sent++;
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // block goes idle: all samples taken, all readings out, closing math finished
    task automatic drain();
        while (sample_q.size() != 0 || s_axis_tvalid || reading_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [ADC_BITS_DEF-1:0] pick_sample(input int style, input int amp);
        case (style)
            0: return ADC_BITS_DEF'($urandom_range(0, 4095));
            1: return ADC_BITS_DEF'($urandom_range(2048 - amp, 2047 + amp));
            2: return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            default: return ADC_BITS_DEF'($urandom_range(2040, 2056));
        endcase
    endfunction

    initial begin
        int          roll;
        int          lim;
        int          len;
        int          style;
        int          amp;
        logic [15:0] cnt;
        logic [15:0] gain;
        logic [15:0] eff;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SAMPLE_COUNT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        in_taken      = 1'b0;
        squeeze_req   = 1'b0;
        squeeze_done  = 1'b0;
        hold_left     = 0;
        n_sent = 0; n_taken = 0; n_blocks = 0; n_cfg = 0; n_err = 0; n_cycles = 0;
        dc_level   = 64'(1 << (ADC_BITS_DEF - 1)) << OFFSET_FRAC_DEF;
        energy_acc = '0;
        blk_seen   = '0;
        reg_count  = SAMPLE_COUNT_RST;
        reg_gain   = ICAL_GAIN_RST;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: a partial block, no reading yet
        send(12'h000); send(12'hFFF); send(12'h000); send(12'hFFF); send(12'h800);
        send(12'h7FF); send(12'hAAA); send(12'h555); send(12'h001); send(12'hFFE);
        drain();
        // count lowered below samples already seen: next sample closes the block
        cfg_write(CFG_SAMPLE_COUNT, 16'd2);
        send(12'hFFF);
        drain();
        // zero count acts as one, full gain saturates the current
        cfg_write(CFG_SAMPLE_COUNT, 16'd0);
        cfg_write(CFG_ICAL_GAIN, 16'hFFFF);
        send(12'h000); send(12'hFFF); send(12'h000); send(12'hFFF);
        drain();
        cfg_write(CFG_ICAL_GAIN, 16'd0);
        send(12'hFFF); send(12'h000);
        drain();
        // longest count, then cut short
        cfg_write(CFG_SAMPLE_COUNT, 16'hFFFF);
        cfg_write(CFG_ICAL_GAIN, 16'd1);
        send(12'hFFF); send(12'h000); send(12'hFFF); send(12'h000); send(12'h800);
        drain();
        cfg_write(CFG_SAMPLE_COUNT, 16'd1);
        send(12'hFFF);
        drain();

        // sink holds off while samples keep coming, so the input backs up
        cfg_write(CFG_ICAL_GAIN, 16'd23270);
        squeeze_req = 1'b1;
        repeat (60) send(pick_sample(0, 0));
        drain();

        while (n_sent < ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) cnt = 16'd0;
            else if (roll < 60) cnt = 16'($urandom_range(1, 8));
            else if (roll < 85) cnt = 16'($urandom_range(9, 40));
            else if (roll < 95) cnt = 16'($urandom_range(41, 300));
            else cnt = 16'hFFFF;
            cfg_write(CFG_SAMPLE_COUNT, cnt);
            if ($urandom_range(0, 9) < 7) begin
                roll = $urandom_range(0, 9);
                if (roll == 0) gain = 16'd0;
                else if (roll == 1) gain = 16'hFFFF;
                else gain = 16'($urandom_range(0, 65535));
                cfg_write(CFG_ICAL_GAIN, gain);
            end
            eff = (cnt == 16'd0) ? 16'd1 : cnt;
            if (cnt == 16'hFFFF) begin
                len = $urandom_range(5, 40);
            end else begin
                lim = 200 / int'(eff);
                if (lim < 1) lim = 1;
                if (lim > 25) lim = 25;
                len = $urandom_range(1, lim) * int'(eff);
                if ($urandom_range(0, 3) == 0) len += $urandom_range(0, int'(eff) - 1);
            end
            if (len > ITEMS - n_sent) len = ITEMS - n_sent;
            style = $urandom_range(0, 3);
            amp   = $urandom_range(1, 2047);
            repeat (len) send(pick_sample(style, amp));
            drain();
        end

        drain();
        $display("covered %0d samples, %0d readings checked, %0d register writes",
                 n_taken, n_blocks, n_cfg);
        $display("block counts from zero to full scale, gains from zero to full scale");
        if (n_err == 0 && reading_q.size() == 0) begin
            $display("rms_current_meter test passed");
        end else begin
            $display("rms_current_meter test failed");
        end
        $finish;
    end

endmodule
